### rtl/swts_pkg.sv
// Package: shared widths, codes and the sequencer control store for the word table search.
package swts_pkg;

   localparam int ENTRY_W = 16;
   localparam int POS_W = 4;
   localparam int CHAR_W = 8;
   localparam int COUNT_W = 17;

   localparam int DEF_MAX_ENTRIES = 65536;
   localparam int DEF_QUERY_CHARS = 10;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_INIT = 3'd1;
   localparam step_type STEP_CHECK = 3'd2;
   localparam step_type STEP_BASE = 3'd3;
   localparam step_type STEP_READ = 3'd4;
   localparam step_type STEP_COMP = 3'd5;
   localparam step_type STEP_EMIT = 3'd6;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_START,
      COND_EMPTY,
      COND_MISMATCH,
      COND_MORE,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      logic     take_item;
      logic     load_bounds;
      logic     load_mid;
      logic     load_base;
      logic     fetch;
      logic     compare;
      logic     deliver;
      cond_type jmp_cond;
      step_type jmp_target;
      cond_type stay_cond;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '0;
      w.jmp_cond = COND_NEVER;
      w.jmp_target = STEP_IDLE;
      w.stay_cond = COND_NEVER;
      case (step)
         STEP_IDLE: begin
            w.take_item = 1'b1;
            w.jmp_cond = COND_START;
            w.jmp_target = STEP_INIT;
            w.stay_cond = COND_ALWAYS;
         end
         STEP_INIT: begin
            w.load_bounds = 1'b1;
         end
         STEP_CHECK: begin
            w.load_mid = 1'b1;
            w.jmp_cond = COND_EMPTY;
            w.jmp_target = STEP_EMIT;
         end
         STEP_BASE: begin
            w.load_base = 1'b1;
         end
         STEP_READ: begin
            w.fetch = 1'b1;
         end
         STEP_COMP: begin
            w.fetch = 1'b1;
            w.compare = 1'b1;
            w.jmp_cond = COND_MISMATCH;
            w.jmp_target = STEP_CHECK;
            w.stay_cond = COND_MORE;
         end
         STEP_EMIT: begin
            w.deliver = 1'b1;
            w.jmp_cond = COND_RSP_FREE;
            w.jmp_target = STEP_IDLE;
            w.stay_cond = COND_ALWAYS;
         end
         default: begin
            w.jmp_cond = COND_ALWAYS;
            w.jmp_target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/swts_if.sv
// Interfaces: request, response and register write channels of the word table search.
interface swts_req_if;
   import swts_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [ENTRY_W-1:0]  entry_index;
   logic [POS_W-1:0]    char_pos;
   logic [CHAR_W-1:0]   char_value;
   logic                last;
   modport source (output valid, op, entry_index, char_pos, char_value, last, input ready);
   modport sink (input valid, op, entry_index, char_pos, char_value, last, output ready);
endinterface

interface swts_rsp_if;
   logic valid;
   logic ready;
   logic found;
   modport source (output valid, found, input ready);
   modport sink (input valid, found, output ready);
endinterface

interface swts_csr_if;
   import swts_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] word_count;
   modport source (output valid, word_count, input ready);
   modport sink (input valid, word_count, output ready);
endinterface

### rtl/sorted_word_table_search.sv
// Top level: binary search of a sorted word table, run by a microcoded sequencer.
// The block accepts one write or query item per cycle while idle; req ready is low while a search runs.
// A search makes at most P <= ceil(log2(word_count + 1)) probes, each comparing bytes through
// the single table read port, which delivers one byte per cycle.
// Synchronous reset clears the sequencer, query length, bounds and word_count; table contents persist.
module sorted_word_table_search #(
   parameter int MAX_ENTRIES = swts_pkg::DEF_MAX_ENTRIES,
   parameter int QUERY_CHARS = swts_pkg::DEF_QUERY_CHARS
) (
   input  logic      clock,
   input  logic      reset,
   swts_req_if.sink  req_if,
   swts_rsp_if.source rsp_if,
   swts_csr_if.sink  csr_if
);
   import swts_pkg::*;

   localparam int SLOT_BYTES = QUERY_CHARS + 1;
   localparam int DEPTH = MAX_ENTRIES * SLOT_BYTES;
   localparam int AW = $clog2(DEPTH);
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int BW = $clog2(MAX_ENTRIES + 1);
   localparam int QIW = (QUERY_CHARS > 1) ? $clog2(QUERY_CHARS) : 1;
   localparam int QLW = $clog2(QUERY_CHARS + 1);
   localparam int IXW = (EW > ENTRY_W) ? EW : ENTRY_W;

   ctrl_word_type      ctrl;
   step_type           step_ff, step_in;
   logic               jmp_hit, stay_hit;

   logic [COUNT_W-1:0] word_count_ff;
   logic [CHAR_W-1:0]  query_ff [QUERY_CHARS];
   logic [QLW-1:0]     query_len_ff;
   logic [BW-1:0]      low_ff, high_ff, limit;
   logic [BW:0]        mid_sum;
   logic [EW-1:0]      mid_ff;
   logic [AW-1:0]      addr_ff;
   logic [QLW-1:0]     byte_ff;
   logic               found_ff;
   logic               rsp_valid_ff, rsp_found_ff;

   logic               req_accept, start_go, write_go, rsp_free, deliver_go;
   logic [IXW-1:0]     wr_entry_wide;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [CHAR_W-1:0]  rd_data, query_byte;
   logic               empty, mismatch, more, word_end;

   assign ctrl = ucode_rom(step_ff);

   assign req_if.ready = ctrl.take_item;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.found = rsp_found_ff;

   assign req_accept = req_if.valid & req_if.ready;
   assign start_go = req_accept & (req_if.op == OP_QUERY) & req_if.last;
   assign rsp_free = ~rsp_valid_ff | rsp_if.ready;
   assign deliver_go = ctrl.deliver & rsp_free;

   assign wr_entry_wide = IXW'(req_if.entry_index);
   assign write_go = req_accept & (req_if.op == OP_WRITE)
                   & ((IXW + 1)'(wr_entry_wide) < (IXW + 1)'(MAX_ENTRIES))
                   & (32'(req_if.char_pos) < 32'(SLOT_BYTES));
   assign wr_addr = AW'(wr_entry_wide[EW-1:0]) * AW'(SLOT_BYTES) + AW'(req_if.char_pos);

   assign limit = (32'(word_count_ff) > 32'(MAX_ENTRIES)) ? BW'(MAX_ENTRIES)
                                                          : BW'(word_count_ff);
   assign mid_sum = (BW + 1)'(low_ff) + (BW + 1)'(high_ff) - (BW + 1)'(1);
   assign empty = ~(low_ff < high_ff);

   assign query_byte = (byte_ff < query_len_ff) ? query_ff[byte_ff[QIW-1:0]] : '0;
   assign mismatch = query_byte != rd_data;
   assign word_end = (query_byte == '0) | (byte_ff == QLW'(SLOT_BYTES - 1));
   assign more = ~mismatch & ~word_end;
   assign rd_en = ctrl.fetch & (~ctrl.compare | more);

   swts_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (write_go),
      .wr_addr (wr_addr),
      .wr_data (req_if.char_value),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      case (ctrl.jmp_cond)
         COND_NEVER:    jmp_hit = 1'b0;
         COND_ALWAYS:   jmp_hit = 1'b1;
         COND_START:    jmp_hit = start_go;
         COND_EMPTY:    jmp_hit = empty;
         COND_MISMATCH: jmp_hit = mismatch;
         COND_MORE:     jmp_hit = more;
         COND_RSP_FREE: jmp_hit = rsp_free;
         default:       jmp_hit = 1'b0;
      endcase
      case (ctrl.stay_cond)
         COND_NEVER:    stay_hit = 1'b0;
         COND_ALWAYS:   stay_hit = 1'b1;
         COND_START:    stay_hit = start_go;
         COND_EMPTY:    stay_hit = empty;
         COND_MISMATCH: stay_hit = mismatch;
         COND_MORE:     stay_hit = more;
         COND_RSP_FREE: stay_hit = rsp_free;
         default:       stay_hit = 1'b0;
      endcase
      if (jmp_hit) begin
         step_in = ctrl.jmp_target;
      end else if (stay_hit) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         word_count_ff <= '0;
         query_len_ff <= '0;
         low_ff <= '0;
         high_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (csr_if.valid & csr_if.ready) begin
            word_count_ff <= csr_if.word_count;
         end
         if (req_accept & (req_if.op == OP_QUERY) & (query_len_ff < QLW'(QUERY_CHARS))) begin
            query_len_ff <= query_len_ff + QLW'(1);
         end else if (deliver_go) begin
            query_len_ff <= '0;
         end
         if (ctrl.load_bounds) begin
            low_ff <= '0;
            high_ff <= limit;
         end else if (ctrl.compare & mismatch) begin
            if (query_byte > rd_data) begin
               low_ff <= BW'(mid_ff) + BW'(1);
            end else begin
               high_ff <= BW'(mid_ff);
            end
         end
         if (deliver_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_accept & (req_if.op == OP_QUERY) & (query_len_ff < QLW'(QUERY_CHARS))) begin
         query_ff[query_len_ff[QIW-1:0]] <= req_if.char_value;
      end
      if (ctrl.load_mid) begin
         mid_ff <= mid_sum[EW:1];
      end
      if (ctrl.load_base) begin
         addr_ff <= AW'(mid_ff) * AW'(SLOT_BYTES);
         byte_ff <= '0;
      end else if (rd_en) begin
         addr_ff <= addr_ff + AW'(1);
         if (ctrl.compare) begin
            byte_ff <= byte_ff + QLW'(1);
         end
      end
      if (ctrl.load_bounds) begin
         found_ff <= 1'b0;
      end else if (ctrl.compare & ~mismatch & ~more) begin
         found_ff <= 1'b1;
      end
      if (deliver_go) begin
         rsp_found_ff <= found_ff;
      end
   end

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("search bounds crossed");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_COMP |-> (BW'(mid_ff) >= low_ff) && (BW'(mid_ff) < high_ff))
      else $error("probe outside search bounds");

   a_byte_in_slot: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_COMP |-> byte_ff <= QLW'(SLOT_BYTES - 1))
      else $error("compare ran past entry slot");

   a_deliver_clears: assert property (@(posedge clock) disable iff (reset)
      deliver_go |=> rsp_valid_ff && (query_len_ff == '0) && (step_ff == STEP_IDLE))
      else $error("delivery did not clear query");

endmodule

### rtl/swts_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module swts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### tb/testbench.sv
// Testbench for sorted_word_table_search: predicts every lookup and checks each response item.
module testbench;
   import swts_pkg::*;

   localparam int QCH = DEF_QUERY_CHARS;
   localparam int SLOT = QCH + 1;
   localparam int TABLE_ENTRIES = DEF_MAX_ENTRIES;
   localparam int DRAIN_CYCLES = 300;
   localparam int LONG_HOLD = 400;
   localparam int ITEM_GOAL = 850;
   localparam int TIMEOUT_CYCLES = 1_000_000;

   typedef bit [7:0] byte_type;
   typedef bit [0:SLOT-1][7:0] word_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock;
   logic reset;

   swts_req_if req ();
   swts_rsp_if rsp ();
   swts_csr_if csr ();

   sorted_word_table_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   byte_type    dict_mem [int];
   word_type    query_buf = '0;
   int          query_len = 0;
   int unsigned word_count_cfg = 0;
   bit          expected_found [$];
   int          errors = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   bit          steady = 0;
   bit          offering = 0;
   bit          long_hold_req = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(10 * TIMEOUT_CYCLES);
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic int strcmp_order(input word_type a, input word_type b);
      for (int i = 0; i < SLOT; i++) begin
         if (a[i] != b[i]) return (a[i] > b[i]) ? 1 : -1;
         if (a[i] == 8'h00) return 0;
      end
      return 0;
   endfunction

   // Walk the binary search; return the first probed entry not fully written, else -1.
   function automatic int probe_table(input word_type key, output bit hit);
      int lo;
      int hi;
      int mid;
      int r;
      word_type entry_w;
      lo = 0;
      hi = (word_count_cfg > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(word_count_cfg);
      hit = 1'b0;
      while (lo < hi) begin
         mid = (lo + hi - 1) >> 1;
         for (int i = 0; i < SLOT; i++) begin
            if (!dict_mem.exists(mid * SLOT + i)) return mid;
            entry_w[i] = dict_mem[mid * SLOT + i];
         end
         r = strcmp_order(key, entry_w);
         if (r == 0) begin
            hit = 1'b1;
            return -1;
         end
         if (r > 0) lo = mid + 1;
         else hi = mid;
      end
      return -1;
   endfunction

   always @(posedge clock) begin
      bit hit;
      int hole;
      if (!reset && req.valid && req.ready) begin
         if (req.op == OP_WRITE) begin
            if (req.char_pos <= QCH)
               dict_mem[int'(req.entry_index) * SLOT + int'(req.char_pos)] = req.char_value;
         end else begin
            if (query_len < QCH) begin
               query_buf[query_len] = req.char_value;
               query_len++;
            end
            if (req.last) begin
               hole = probe_table(query_buf, hit);
               if (hole >= 0)
                  report_mismatch($sformatf("lookup reads unwritten entry %0d", hole));
               expected_found.push_back(hit);
               query_buf = '0;
               query_len = 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && csr.valid && csr.ready) word_count_cfg = csr.word_count;
   end

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_found.size() == 0) begin
            report_mismatch("response item with no lookup pending");
         end else begin
            want = expected_found.pop_front();
            if (rsp.found !== want)
               report_mismatch($sformatf("found %b, expected %b", rsp.found, want));
         end
      end
   end

   initial begin
      int rx_left;
      rx_mode_type rx_mode;
      rx_left = 0;
      rx_mode = RX_OPEN;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_left = $urandom_range(16, 128);
            end
            rx_left--;
            case (rx_mode)
               RX_OPEN: rsp.ready <= 1'b1;
               RX_COIN: rsp.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
               default: rsp.ready <= ((rx_left % 8) < 5);
            endcase
         end
      end
   end

   task automatic send_item(input logic op, input logic [ENTRY_W-1:0] entry,
                            input logic [POS_W-1:0] pos, input byte_type ch, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            if (offering) req.valid <= 1'b0;
            offering = 0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
      req.valid <= 1'b1;
      req.op <= op;
      req.entry_index <= entry;
      req.char_pos <= pos;
      req.char_value <= ch;
      req.last <= last;
      offering = 1;
      if (!(op == OP_WRITE && pos > QCH)) items_sent++;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic hold_requests();
      if (offering) req.valid <= 1'b0;
      offering = 0;
   endtask

   task automatic wait_drained();
      while (expected_found.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_word_count(input int unsigned value);
      hold_requests();
      wait_drained();
      csr.valid <= 1'b1;
      csr.word_count <= value[COUNT_W-1:0];
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic word_type make_word();
      word_type w;
      int len;
      w = '0;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, QCH) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
         w[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'(8'h61 + $urandom_range(0, 3));
      if (len == QCH && $urandom_range(0, 3) == 0) w[QCH] = 8'($urandom_range(1, 255));
      return w;
   endfunction

   task automatic write_entry(input int e, input word_type w);
      for (int i = 0; i < SLOT; i++)
         send_item(OP_WRITE, 16'(e), 4'(i), w[i], 1'($urandom_range(0, 1)));
   endtask

   // Fill every probed entry that is still blank, then send the query bytes.
   task automatic run_query(input byte_type chars [$]);
      word_type key;
      int hole;
      bit hit;
      key = '0;
      for (int i = 0; i < chars.size() && i < QCH; i++) key[i] = chars[i];
      hole = probe_table(key, hit);
      while (hole >= 0) begin
         write_entry(hole, ($urandom_range(0, 2) == 0) ? key : make_word());
         hole = probe_table(key, hit);
      end
      for (int i = 0; i < chars.size(); i++)
         send_item(OP_QUERY, 16'($urandom), 4'($urandom), chars[i], i == chars.size() - 1);
   endtask

   task automatic query_word(input word_type w);
      byte_type chars [$];
      for (int i = 0; i < QCH && w[i] != 8'h00; i++) chars.push_back(w[i]);
      case ($urandom_range(0, 9))
         0: repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom));
         1: begin
            chars.push_back(8'h00);
            chars.push_back(8'($urandom));
         end
         2: if (chars.size() > 0) chars[chars.size() - 1] = 8'($urandom);
         default: ;
      endcase
      if (chars.size() == 0) chars.push_back(8'h00);
      run_query(chars);
   endtask

   task automatic test_empty_count();
      byte_type chars [$];
      set_word_count(0);
      chars = '{8'h61};
      run_query(chars);
   endtask

   task automatic test_table_edges();
      word_type w;
      byte_type chars [$];
      w = '0;
      w[0] = 8'h61;
      write_entry(0, w);
      w = '0;
      for (int i = 0; i < QCH; i++) w[i] = 8'hff;
      write_entry(1, w);
      send_item(OP_WRITE, 16'd0, 4'hf, 8'hff, 1'b1);
      set_word_count(2);
      chars = '{8'h61};
      run_query(chars);
      chars = '{8'h61, 8'h00, 8'h71};
      run_query(chars);
      chars = {};
      repeat (QCH) chars.push_back(8'hff);
      chars.push_back(8'h01);
      run_query(chars);
      chars = '{8'h00};
      run_query(chars);
      chars = '{8'h62};
      run_query(chars);
   endtask

   task automatic test_output_backpressure();
      word_type w;
      steady = 1;
      long_hold_req = 1;
      repeat (4) begin
         w = '0;
         w[0] = 8'h61;
         query_word(($urandom_range(0, 1) == 0) ? w : make_word());
      end
      steady = 0;
   endtask

   task automatic test_scattered_table(input int unsigned count, input int queries);
      set_word_count(count);
      repeat (queries) query_word(make_word());
   endtask

   task automatic test_count_limits();
      test_scattered_table(TABLE_ENTRIES, 1);
      test_scattered_table(TABLE_ENTRIES + 1, 1);
      test_scattered_table((1 << COUNT_W) - 1, 1);
   endtask

   task automatic test_sorted_table(input int entries);
      word_type words [$];
      word_type w;
      int j;
      for (int i = 0; i < entries; i++) begin
         w = make_word();
         j = words.size();
         words.push_back(w);
         while (j > 0 && words[j-1] > w) begin
            words[j] = words[j-1];
            j--;
         end
         words[j] = w;
      end
      for (int i = 0; i < entries; i++) write_entry(i, words[i]);
      repeat ($urandom_range(0, 3))
         send_item(OP_WRITE, 16'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      set_word_count(($urandom_range(0, 3) == 0) ? entries + $urandom_range(0, 3) : entries);
      repeat ($urandom_range(6, 12))
         query_word(($urandom_range(0, 1) == 0) ? words[$urandom_range(0, entries - 1)]
                                                : make_word());
   endtask

   task automatic test_random_tables();
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 3) == 0)
            test_scattered_table(($urandom_range(0, 7) == 0)
                                 ? $urandom_range(1000, (1 << COUNT_W) - 1)
                                 : $urandom_range(1, 300), $urandom_range(2, 5));
         else
            test_sorted_table($urandom_range(1, 8));
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = OP_WRITE;
      req.entry_index = '0;
      req.char_pos = '0;
      req.char_value = '0;
      req.last = 1'b0;
      csr.valid = 1'b0;
      csr.word_count = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_count();
      test_table_edges();
      test_output_backpressure();
      test_count_limits();
      test_random_tables();
      hold_requests();
      wait_drained();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
